// File: design/octl_pkg.sv
// Package for the octree leaf lookup: sizes, operation codes, states and shared types.
package octl_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = 12;
  localparam int COORD_BITS = 32;
  localparam int MAX_DEPTH  = 16;
  localparam int DEPTH_W    = 5;
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 3;

  localparam logic [NODE_W:0]    NODE_LIMIT = (NODE_W + 1)'(NODE_COUNT);
  localparam logic [NODE_W-1:0]  LAST_NODE  = NODE_W'(NODE_COUNT - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_CAP  = DEPTH_W'(MAX_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE_CENTER = 2'd0,
    OP_WRITE_CHILD  = 2'd1,
    OP_QUERY        = 2'd2,
    OP_UNUSED       = 2'd3
  } octl_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } octl_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } octl_center_t;

  typedef logic [SLOT_COUNT-1:0][NODE_W-1:0] octl_row_t;

  // One write command into the node memory.
  typedef struct packed {
    logic               clear;
    logic               center_we;
    logic               child_we;
    logic [NODE_W-1:0]  addr;
    logic [SLOT_W-1:0]  slot;
    logic [NODE_W-1:0]  target;
    octl_center_t       center;
  } octl_wr_t;

endpackage

// File: design/octl_node_mem.sv
// Node memory: one row of eight child indices and one center per node, registered read.
module octl_node_mem
  import octl_pkg::*;
(
  input  logic              clk,
  input  octl_wr_t          wr,
  input  logic              rd_en,
  input  logic [NODE_W-1:0] rd_addr,
  output octl_row_t         rd_row,
  output octl_center_t      rd_center
);

  octl_row_t    child_mem  [NODE_COUNT];
  octl_center_t center_mem [NODE_COUNT];
  octl_row_t    rd_row_r;
  octl_center_t rd_center_r;

  // Child slots are written one lane at a time; the clearing pass zeroes a whole row.
  always_ff @(posedge clk) begin
    if (wr.clear) begin
      child_mem[wr.addr] <= '0;
    end else if (wr.child_we) begin
      child_mem[wr.addr][wr.slot] <= wr.target;
    end
    if (rd_en) begin
      rd_row_r <= child_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.center_we) begin
      center_mem[wr.addr] <= wr.center;
    end
    if (rd_en) begin
      rd_center_r <= center_mem[rd_addr];
    end
  end

  assign rd_row    = rd_row_r;
  assign rd_center = rd_center_r;

endmodule

// File: design/octree_leaf_lookup.sv
// Top level of the octree leaf lookup: handshakes, walk sequencer and result register.
//
// The block holds a table of 4096 octree nodes, each with a signed Q16.16 center and eight
// child indices. A write item loads one node center or one child slot. A query item walks
// from the root, node 0: at each node the octant comes from signed greater-than tests of
// the point against the center (x gives bit 0, y bit 1, z bit 2) and the walk follows that
// child. A node whose first child slot is zero is a leaf; an empty octant below a non-leaf
// leads back to node 0. A walk that reaches depth 16 on an inner node stops there with the
// overrun flag set. Each level has a synchronous read of the node row, then the octant
// compare and child select. The block takes no item while a query walks. After reset a
// clearing pass zeroes the child table, one node row per cycle, holding in_ready low until
// the pass is done.
// A finished result waits in the output register; write items are still taken meanwhile,
// and a following query stalls only at its end until that result is taken.
module octree_leaf_lookup
  import octl_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [NODE_W-1:0]            in_node_index,
  input  logic [SLOT_W-1:0]            in_child_slot,
  input  logic [NODE_W-1:0]            in_child_target,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic signed [COORD_BITS-1:0] in_coord_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [NODE_W-1:0]            out_leaf_index,
  output logic [DEPTH_W-1:0]           out_leaf_depth,
  output logic                         out_depth_overrun
);

  octl_state_t       state_r, state_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  octl_center_t      point_r, point_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]  out_index_r, out_index_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic               out_over_r, out_over_nxt;

  octl_wr_t     wr;
  logic         rd_en;
  octl_row_t    rd_row;
  octl_center_t rd_center;

  logic              accept;
  logic              node_ok;
  logic              target_ok;
  logic              slot_free;
  logic [SLOT_W-1:0] octant;

  octl_node_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (cur_r),
    .rd_row    (rd_row),
    .rd_center (rd_center)
  );

  assign accept    = in_valid && in_ready;
  assign node_ok   = {1'b0, in_node_index} < NODE_LIMIT;
  assign target_ok = {1'b0, in_child_target} < NODE_LIMIT;
  assign slot_free = !out_valid_r || out_ready;

  // The node compare unit: three signed compares of the held point against the center
  // that was just read, reused at every level of the walk.
  assign octant = {point_r.z > rd_center.z, point_r.y > rd_center.y,
                   point_r.x > rd_center.x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    depth_r     <= depth_nxt;
    point_r     <= point_nxt;
    out_index_r <= out_index_nxt;
    out_depth_r <= out_depth_nxt;
    out_over_r  <= out_over_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    depth_nxt     = depth_r;
    point_nxt     = point_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_depth_nxt = out_depth_r;
    out_over_nxt  = out_over_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;

    wr           = '0;
    wr.addr      = in_node_index;
    wr.slot      = in_child_slot;
    wr.target    = in_child_target;
    wr.center.x  = in_coord_x;
    wr.center.y  = in_coord_y;
    wr.center.z  = in_coord_z;

    case (state_r)
      ST_CLEAR: begin
        // Zero one child row per cycle until the whole table is clean.
        wr.clear = 1'b1;
        wr.addr  = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (octl_op_t'(in_operation))
            OP_WRITE_CENTER: begin
              wr.center_we = node_ok;
            end
            OP_WRITE_CHILD: begin
              wr.child_we = node_ok && target_ok;
            end
            OP_QUERY: begin
              cur_nxt     = '0;
              depth_nxt   = '0;
              point_nxt.x = in_coord_x;
              point_nxt.y = in_coord_y;
              point_nxt.z = in_coord_z;
              state_nxt   = ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (rd_row[0] == '0 || depth_r == DEPTH_CAP) begin
          // Leaf reached, or the cap stops the walk on an inner node.
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = cur_r;
            out_depth_nxt = depth_r;
            out_over_nxt  = rd_row[0] != '0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cur_nxt   = rd_row[octant];
          depth_nxt = depth_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_leaf_index    = out_index_r;
  assign out_leaf_depth    = out_depth_r;
  assign out_depth_overrun = out_over_r;

  a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_EVAL)
    else $error("result appeared without a finished walk");

  a_overrun_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_depth_overrun) |-> out_leaf_depth == DEPTH_CAP)
    else $error("overrun flagged below the depth cap");

  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_EVAL) |-> depth_r <= DEPTH_CAP)
    else $error("walk went deeper than the cap");

  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_QUERY) |=> (state_r == ST_READ && cur_r == '0))
    else $error("query did not start at the root");

endmodule
